>>> rtl/core/sst_pkg.sv
// Shared types and constants for the sorted set table.
package sst_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_QUERY  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic                     cmp;
        logic                     shift_up;
        logic                     shift_down;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

>>> rtl/core/sorted_set_table.sv
// Sorted set of distinct signed 32-bit values held in a row of compare-and-shift cells.
// Each request (add, remove or contains, chosen by s_axis_tuser) is registered when taken,
// compared against all cells in the compare state, and in the update state the row shifts
// up or down by one slot while the result is loaded into the output register. The update
// state waits while a result that is not taken holds the output register, and a new request
// is taken only in idle, once the compare phase and the shift phase of the previous one end.
// A request may be accepted while the previous result still waits downstream. An add of
// a new value into a full set is dropped and flagged; count is the low 5 bits of the size.
module sorted_set_table
    import sst_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value (signed)
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] was_present, [1] changed, [2] full_drop,
                                        // [7:3] count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state                   r_state;
    t_state                   n_state;
    t_func                    r_func;
    logic signed [DATA_W-1:0] r_value;
    logic [CNT_W-1:0]         r_held;
    logic [CNT_W-1:0]         n_held;
    logic                     r_out_valid;
    logic [7:0]               r_out_data;

    t_cell_ctl                w_ctl;
    logic signed [DATA_W-1:0] w_entry [CAPACITY];
    logic [CAPACITY-1:0]      w_lt;
    logic [CAPACITY-1:0]      w_eq;
    logic                     w_present;
    logic                     w_full;
    logic                     w_out_free;
    logic                     w_upd_go;
    logic                     w_in_acc;
    logic [CNT_W+COUNT_W-1:0] w_count_ext;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_present  = |w_eq;
    assign w_full     = (r_held == CNT_W'(CAPACITY));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_in_acc) n_state = ST_CMP;
            ST_CMP:  n_state = ST_UPD;
            ST_UPD:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready    = (r_state == ST_IDLE);
        w_upd_go         = (r_state == ST_UPD) && w_out_free;
        w_ctl.cmp        = (r_state == ST_CMP);
        w_ctl.value      = r_value;
        w_ctl.shift_up   = w_upd_go && (r_func == FUNC_ADD) && !w_present && !w_full;
        w_ctl.shift_down = w_upd_go && (r_func == FUNC_REMOVE) && w_present;
    end

    always_comb begin
        n_held = r_held;
        if (w_ctl.shift_up) begin
            n_held = r_held + 1'b1;
        end else if (w_ctl.shift_down) begin
            n_held = r_held - 1'b1;
        end
    end

    assign w_count_ext = {{COUNT_W{1'b0}}, n_held};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            if (w_upd_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_value <= s_axis_tdata;
            unique case (s_axis_tuser)
                FUNC_ADD:    r_func <= FUNC_ADD;
                FUNC_REMOVE: r_func <= FUNC_REMOVE;
                default:     r_func <= FUNC_QUERY;
            endcase
        end
        if (w_upd_go) begin
            r_out_data <= {w_count_ext[COUNT_W-1:0],
                           (r_func == FUNC_ADD) && !w_present && w_full,
                           w_ctl.shift_up || w_ctl.shift_down,
                           w_present};
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [DATA_W-1:0] w_prev_entry;
            logic                     w_prev_lt;
            logic signed [DATA_W-1:0] w_next_entry;

            if (gi == 0) begin : g_first
                assign w_prev_entry = '0;
                assign w_prev_lt    = 1'b1;
            end else begin : g_mid
                assign w_prev_entry = w_entry[gi-1];
                assign w_prev_lt    = w_lt[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign w_next_entry = w_entry[gi];
            end else begin : g_inner
                assign w_next_entry = w_entry[gi+1];
            end

            sst_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_held       (r_held),
                .i_prev_entry (w_prev_entry),
                .i_prev_lt    (w_prev_lt),
                .i_next_entry (w_next_entry),
                .o_entry      (w_entry[gi]),
                .o_lt         (w_lt[gi]),
                .o_eq         (w_eq[gi])
            );
        end
    endgenerate

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> rtl/core/sst_cell.sv
// One slot of the sorted row: holds an entry, compares it and shifts with its neighbors.
module sst_cell
    import sst_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic [CNT_W-1:0]         i_held,
    input  logic signed [DATA_W-1:0] i_prev_entry,
    input  logic                     i_prev_lt,
    input  logic signed [DATA_W-1:0] i_next_entry,
    output logic signed [DATA_W-1:0] o_entry,
    output logic                     o_lt,
    output logic                     o_eq
);

    logic signed [DATA_W-1:0] r_entry;
    logic signed [DATA_W-1:0] n_entry;
    logic                     r_lt;
    logic                     r_eq;
    logic                     w_occ;

    assign w_occ = (i_held > CNT_W'(IDX));

    // Flags form a thermometer: cells below the insert point stay put.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift_up && !r_lt) begin
            n_entry = i_prev_lt ? i_ctl.value : i_prev_entry;
        end else if (i_ctl.shift_down && !r_lt) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctl.cmp) begin
            r_lt <= w_occ && (r_entry < i_ctl.value);
            r_eq <= w_occ && (r_entry == i_ctl.value);
        end
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

>>> rtl/core/sst_checker.sv
// Port-level assertions for the sorted set table, bound to the top level.
module sst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // Stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // One request in flight: no new request right after one is taken.
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // A dropped add neither found the value nor changed the set.
    a_drop_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[0] && !m_axis_tdata[1])
        else $error("full drop with present or changed set");

    // A fresh result is offered only after its request was taken and passed the compare and update states.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3))
        else $error("result without request");

endmodule

bind sorted_set_table sst_checker u_sst_checker (.*);
